### rtl/core/gbi_pkg.sv
package gbi_pkg;

   localparam int GRID_DEPTH  = 4096;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_W      = $clog2(GRID_DEPTH);

   localparam int INDEX_W   = 12;
   localparam int POS_W     = 32;
   localparam int CSR_W     = 32;
   localparam int CSR_IDX_W = 3;
   localparam int CELL_W    = 6;
   localparam int PITCH_W   = CELL_W + 1;
   // largest neighbor address is 63 + 63*65 + 66 = 4224
   localparam int CALC_W    = 2 * CELL_W + 1;
   localparam int FRAC_W    = 17;
   localparam int WGT_W     = 2 * FRAC_W - 1;
   localparam int MUL_W     = POS_W + CSR_W;
   localparam int PROD_W    = VALUE_WIDTH + WGT_W + 1;
   localparam int ACC_W     = PROD_W + 2;

   localparam logic [FRAC_W-1:0] FRAC_ONE = 17'h1_0000;
   localparam logic [MUL_W-1:0]  HALF_Q32 = 64'h0000_0000_8000_0000;

   localparam int CMDQ_DEPTH = 2;

   typedef enum logic {
      FUNC_WRITE  = 1'b0,
      FUNC_INTERP = 1'b1
   } func_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_CELLS_X    = 3'd0,
      CSR_CELLS_Y    = 3'd1,
      CSR_INV_MESH_X = 3'd2,
      CSR_INV_MESH_Y = 3'd3,
      CSR_STAGGER_X  = 3'd4,
      CSR_STAGGER_Y  = 3'd5
   } csr_idx_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_MUL,
      F_CLASS,
      F_PUSH
   } front_state_type;

   typedef enum logic {
      B_IDLE,
      B_READ
   } back_state_type;

   // neighbor order: (x,y) (x+1,y) (x,y+1) (x+1,y+1)
   typedef enum logic [1:0] {
      NB_00,
      NB_10,
      NB_01,
      NB_11
   } nbr_type;

   typedef struct packed {
      func_type                func;
      logic [INDEX_W-1:0]      cell_index;
      logic [VALUE_WIDTH-1:0]  cell_value;
      logic [CALC_W-1:0]       base;
      logic [PITCH_W-1:0]      pitch;
      logic                    clamp;
      logic [WGT_W-1:0]        w00;
      logic [WGT_W-1:0]        w10;
      logic [WGT_W-1:0]        w01;
      logic [WGT_W-1:0]        w11;
   } cmd_type;

endpackage

### rtl/core/gbi_ram.sv
module gbi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end else if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

### rtl/core/gbi_front.sv
module gbi_front import gbi_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_func,
   input  logic [INDEX_W-1:0]            req_cell_index,
   input  logic signed [VALUE_WIDTH-1:0] req_cell_value,
   input  logic signed [POS_W-1:0]       req_pos_x,
   input  logic signed [POS_W-1:0]       req_pos_y,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_W-1:0]              csr_data,
   output logic                          cmd_push,
   output cmd_type                       cmd_data,
   input  logic                          cmd_full
);

   typedef struct packed {
      logic [CELL_W-1:0] idx;
      logic [FRAC_W-1:0] frac;
      logic              clamp;
   } axis_type;

   function automatic axis_type map_axis(input logic neg, input logic [MUL_W-1:0] prod,
                                         input logic [CELL_W-1:0] cells);
      axis_type         r;
      logic [MUL_W-1:0] q;
      q = prod - HALF_Q32;
      if (neg || (prod < HALF_Q32)) begin
         r = '{idx: '0, frac: '0, clamp: 1'b1};
      end else if (q[MUL_W-1:32] > 32'(cells)) begin
         r = '{idx: cells, frac: FRAC_ONE, clamp: 1'b1};
      end else begin
         r = '{idx: q[32 +: CELL_W], frac: {1'b0, q[31:16]}, clamp: 1'b0};
      end
      return r;
   endfunction

   logic [CELL_W-1:0]  cells_x_ff, cells_y_ff;
   logic [CSR_W-1:0]   inv_x_ff, inv_y_ff;
   logic [POS_W-1:0]   stag_x_ff, stag_y_ff;

   front_state_type        state_ff, state_in;
   func_type               func_ff;
   logic [INDEX_W-1:0]     index_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   logic [POS_W:0]         dx_ff, dy_ff, dx_in, dy_in;
   logic [MUL_W-1:0]       prod_x_ff, prod_y_ff, prod_x_in, prod_y_in;
   axis_type               ax_ff, ay_ff, ax_in, ay_in;
   logic                   load_en, mul_en, class_en;
   logic [FRAC_W-1:0]      wx0, wy0;
   logic [PITCH_W-1:0]     pitch;

   always_ff @(posedge clock) begin
      if (reset) begin
         cells_x_ff <= CELL_W'(62);
         cells_y_ff <= CELL_W'(62);
         inv_x_ff   <= CSR_W'(65536);
         inv_y_ff   <= CSR_W'(65536);
         stag_x_ff  <= '0;
         stag_y_ff  <= '0;
      end else if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_CELLS_X:    cells_x_ff <= csr_data[CELL_W-1:0];
            CSR_CELLS_Y:    cells_y_ff <= csr_data[CELL_W-1:0];
            CSR_INV_MESH_X: inv_x_ff   <= csr_data;
            CSR_INV_MESH_Y: inv_y_ff   <= csr_data;
            CSR_STAGGER_X:  stag_x_ff  <= csr_data[POS_W-1:0];
            CSR_STAGGER_Y:  stag_y_ff  <= csr_data[POS_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_en) begin
         func_ff  <= func_type'(req_func);
         index_ff <= req_cell_index;
         value_ff <= req_cell_value;
         dx_ff    <= dx_in;
         dy_ff    <= dy_in;
      end
      if (mul_en) begin
         prod_x_ff <= prod_x_in;
         prod_y_ff <= prod_y_in;
      end
      if (class_en) begin
         ax_ff <= ax_in;
         ay_ff <= ay_in;
      end
   end

   assign dx_in     = {req_pos_x[POS_W-1], req_pos_x} + {stag_x_ff[POS_W-1], stag_x_ff};
   assign dy_in     = {req_pos_y[POS_W-1], req_pos_y} + {stag_y_ff[POS_W-1], stag_y_ff};
   assign prod_x_in = MUL_W'(dx_ff[POS_W-1:0]) * MUL_W'(inv_x_ff);
   assign prod_y_in = MUL_W'(dy_ff[POS_W-1:0]) * MUL_W'(inv_y_ff);
   assign ax_in     = map_axis(dx_ff[POS_W], prod_x_ff, cells_x_ff);
   assign ay_in     = map_axis(dy_ff[POS_W], prod_y_ff, cells_y_ff);

   always_comb begin
      state_in = state_ff;
      load_en  = 1'b0;
      mul_en   = 1'b0;
      class_en = 1'b0;
      cmd_push = 1'b0;
      req_full = 1'b1;
      case (state_ff)
         F_IDLE: begin
            req_full = 1'b0;
            if (req_push) begin
               load_en  = 1'b1;
               state_in = (func_type'(req_func) == FUNC_INTERP) ? F_MUL : F_PUSH;
            end
         end
         F_MUL: begin
            mul_en   = 1'b1;
            state_in = F_CLASS;
         end
         F_CLASS: begin
            class_en = 1'b1;
            state_in = F_PUSH;
         end
         F_PUSH: begin
            if (!cmd_full) begin
               cmd_push = 1'b1;
               state_in = F_IDLE;
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   assign wx0   = FRAC_ONE - ax_ff.frac;
   assign wy0   = FRAC_ONE - ay_ff.frac;
   assign pitch = {1'b0, cells_x_ff} + PITCH_W'(2);

   always_comb begin
      cmd_data.func       = func_ff;
      cmd_data.cell_index = index_ff;
      cmd_data.cell_value = value_ff;
      cmd_data.base       = CALC_W'(ax_ff.idx) + CALC_W'(ay_ff.idx) * CALC_W'(pitch);
      cmd_data.pitch      = pitch;
      cmd_data.clamp      = ax_ff.clamp | ay_ff.clamp;
      cmd_data.w00        = WGT_W'(wx0) * WGT_W'(wy0);
      cmd_data.w10        = WGT_W'(ax_ff.frac) * WGT_W'(wy0);
      cmd_data.w01        = WGT_W'(wx0) * WGT_W'(ay_ff.frac);
      cmd_data.w11        = WGT_W'(ax_ff.frac) * WGT_W'(ay_ff.frac);
   end

endmodule

### rtl/core/gbi_cmd_queue.sv
module gbi_cmd_queue import gbi_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  cmd_type push_data,
   output logic    full,
   input  logic    pop,
   output cmd_type head,
   output logic    empty
);

   localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
   localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

   cmd_type            mem_ff [CMDQ_DEPTH];
   logic [PTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]   count_ff;
   logic               do_push, do_pop;

   assign full    = (count_ff == CNT_W'(CMDQ_DEPTH));
   assign empty   = (count_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign head    = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

### rtl/core/gbi_back.sv
module gbi_back import gbi_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_empty,
   input  cmd_type                cmd_head,
   output logic                   cmd_pop,
   output logic                   ram_we,
   output logic                   ram_re,
   output logic [ADDR_W-1:0]      ram_addr,
   output logic [VALUE_WIDTH-1:0] ram_wdata,
   input  logic [VALUE_WIDTH-1:0] ram_rdata,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic [VALUE_WIDTH-1:0] rsp_interp_value,
   output logic                   rsp_clamped
);

   localparam int SHIFT_W = ACC_W - 32;

   back_state_type state_ff, state_in;
   nbr_type        cnt_ff, cnt_in, widx;
   cmd_type        cur_ff, src;
   logic           load_cur, issue, inrange, stall;
   logic [CALC_W-1:0] calc_addr;
   logic [WGT_W-1:0]  wsel;

   logic                   s1_valid_ff, s1_inr_ff, s1_first_ff, s1_last_ff, s1_clamp_ff;
   logic [WGT_W-1:0]       s1_w_ff;
   logic [VALUE_WIDTH-1:0] s1_val;
   logic signed [PROD_W-1:0] prod_in, s2_prod_ff;
   logic                   s2_valid_ff, s2_first_ff, s2_last_ff, s2_clamp_ff;
   logic signed [ACC_W-1:0] acc_ff, acc_in, fin_acc_ff, rnd;
   logic                   fin_valid_ff, fin_clamp_ff, fin_move, out_take;
   logic [SHIFT_W-1:0]     shifted;
   logic [SHIFT_W-VALUE_WIDTH:0] top_bits;
   logic [VALUE_WIDTH-1:0] sat_value;
   logic                   out_valid_ff, out_clamp_ff;
   logic [VALUE_WIDTH-1:0] out_value_ff;

   assign out_take = rsp_pop && out_valid_ff;
   assign fin_move = fin_valid_ff && (!out_valid_ff || out_take);
   assign stall    = fin_valid_ff && !fin_move;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd_pop  = 1'b0;
      load_cur = 1'b0;
      issue    = 1'b0;
      ram_we   = 1'b0;
      widx     = NB_00;
      src      = cur_ff;
      case (state_ff)
         B_IDLE: begin
            src = cmd_head;
            if (!stall && !cmd_empty) begin
               cmd_pop = 1'b1;
               if (cmd_head.func == FUNC_WRITE) begin
                  ram_we = (32'(cmd_head.cell_index) < GRID_DEPTH);
               end else begin
                  issue    = 1'b1;
                  load_cur = 1'b1;
                  cnt_in   = NB_10;
                  state_in = B_READ;
               end
            end
         end
         B_READ: begin
            if (!stall) begin
               issue  = 1'b1;
               widx   = cnt_ff;
               cnt_in = nbr_type'(cnt_ff + 2'd1);
               if (cnt_ff == NB_11) begin
                  state_in = B_IDLE;
               end
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      calc_addr = src.base + (widx[1] ? CALC_W'(src.pitch) : '0) + CALC_W'(widx[0]);
      inrange   = (32'(calc_addr) < GRID_DEPTH);
      ram_re    = issue && inrange;
      ram_addr  = ram_we ? ADDR_W'(cmd_head.cell_index) : ADDR_W'(calc_addr);
      ram_wdata = cmd_head.cell_value;
      case (widx)
         NB_00:   wsel = src.w00;
         NB_10:   wsel = src.w10;
         NB_01:   wsel = src.w01;
         NB_11:   wsel = src.w11;
         default: wsel = src.w00;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         cnt_ff       <= NB_00;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         if (!stall) begin
            s1_valid_ff  <= issue;
            s2_valid_ff  <= s1_valid_ff;
            fin_valid_ff <= (s2_valid_ff && s2_last_ff) ? 1'b1 : 1'b0;
         end
         if (fin_move) begin
            out_valid_ff <= 1'b1;
         end else if (out_take) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   assign s1_val  = s1_inr_ff ? ram_rdata : '0;
   assign prod_in = $signed(s1_val) * $signed({1'b0, s1_w_ff});
   assign acc_in  = (s2_first_ff ? '0 : acc_ff) + ACC_W'(s2_prod_ff);

   always_ff @(posedge clock) begin
      if (load_cur) begin
         cur_ff <= cmd_head;
      end
      if (!stall) begin
         s1_inr_ff   <= inrange;
         s1_w_ff     <= wsel;
         s1_first_ff <= (widx == NB_00);
         s1_last_ff  <= (widx == NB_11);
         s1_clamp_ff <= src.clamp;
         s2_prod_ff  <= prod_in;
         s2_first_ff <= s1_first_ff;
         s2_last_ff  <= s1_last_ff;
         s2_clamp_ff <= s1_clamp_ff;
         if (s2_valid_ff) begin
            acc_ff <= acc_in;
         end
         if (s2_valid_ff && s2_last_ff) begin
            fin_acc_ff   <= acc_in;
            fin_clamp_ff <= s2_clamp_ff;
         end
      end
      if (fin_move) begin
         out_value_ff <= sat_value;
         out_clamp_ff <= fin_clamp_ff;
      end
   end

   // round half up, drop 32 fraction bits, saturate
   always_comb begin
      rnd      = fin_acc_ff + ACC_W'(HALF_Q32);
      shifted  = rnd[ACC_W-1:32];
      top_bits = shifted[SHIFT_W-1:VALUE_WIDTH-1];
      if ((&top_bits) || !(|top_bits)) begin
         sat_value = shifted[VALUE_WIDTH-1:0];
      end else if (shifted[SHIFT_W-1]) begin
         sat_value = {1'b1, {(VALUE_WIDTH-1){1'b0}}};
      end else begin
         sat_value = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
      end
   end

   assign rsp_empty        = !out_valid_ff;
   assign rsp_interp_value = out_value_ff;
   assign rsp_clamped      = out_clamp_ff;

endmodule

### rtl/core/grid_bilinear_interpolation.sv
// Bilinear lookup on a 2-D grid with a one-cell ghost border, row pitch cells_x+2.
// A write transaction (func 0) stores one Q16.16 cell and returns nothing; an
// interpolate transaction (func 1) maps pos_x/pos_y into grid space, blends the
// four surrounding cells and returns one saturated Q16.16 value plus a clamp flag.
// Cells read before being written return unspecified data. The front end takes an
// interpolate through accept, 32x32 scale multiply, classify and hand-off steps and a
// write through accept and hand-off, and takes no new transaction before hand-off; the
// back end holds the single-port grid RAM for the four neighbor reads of an interpolate
// (one neighbor read per cycle while the result output is not stalled) or for the single
// RAM write of a write transaction.
// Configuration may only be written while no transaction is in flight.
module grid_bilinear_interpolation import gbi_pkg::*; (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_push,
   output logic                          req_full,
   input  logic                          req_func,
   input  logic [INDEX_W-1:0]            req_cell_index,
   input  logic signed [VALUE_WIDTH-1:0] req_cell_value,
   input  logic signed [POS_W-1:0]       req_pos_x,
   input  logic signed [POS_W-1:0]       req_pos_y,
   output logic                          rsp_empty,
   input  logic                          rsp_pop,
   output logic signed [VALUE_WIDTH-1:0] rsp_interp_value,
   output logic                          rsp_clamped,
   input  logic                          csr_we,
   input  logic [CSR_IDX_W-1:0]          csr_index,
   input  logic [CSR_W-1:0]              csr_data
);

   logic                   cmd_push, cmd_full, cmd_pop, cmd_empty;
   cmd_type                cmd_data, cmd_head;
   logic                   ram_we, ram_re;
   logic [ADDR_W-1:0]      ram_addr;
   logic [VALUE_WIDTH-1:0] ram_wdata, ram_rdata, rsp_value;

   gbi_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_func       (req_func),
      .req_cell_index (req_cell_index),
      .req_cell_value (req_cell_value),
      .req_pos_x      (req_pos_x),
      .req_pos_y      (req_pos_y),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .cmd_push       (cmd_push),
      .cmd_data       (cmd_data),
      .cmd_full       (cmd_full)
   );

   gbi_cmd_queue u_cmd_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .head      (cmd_head),
      .empty     (cmd_empty)
   );

   gbi_back u_back (
      .clock            (clock),
      .reset            (reset),
      .cmd_empty        (cmd_empty),
      .cmd_head         (cmd_head),
      .cmd_pop          (cmd_pop),
      .ram_we           (ram_we),
      .ram_re           (ram_re),
      .ram_addr         (ram_addr),
      .ram_wdata        (ram_wdata),
      .ram_rdata        (ram_rdata),
      .rsp_empty        (rsp_empty),
      .rsp_pop          (rsp_pop),
      .rsp_interp_value (rsp_value),
      .rsp_clamped      (rsp_clamped)
   );

   gbi_ram #(
      .WIDTH (VALUE_WIDTH),
      .DEPTH (GRID_DEPTH)
   ) u_grid_ram (
      .clock (clock),
      .we    (ram_we),
      .re    (ram_re),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   assign rsp_interp_value = rsp_value;

   a_ram_single_port: assert property (@(posedge clock) disable iff (reset)
      !(ram_we && ram_re))
      else $error("grid RAM read and write in the same cycle");

   a_cmd_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> !cmd_full)
      else $error("command pushed into full queue");

   a_cmd_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("command popped from empty queue");

   a_write_from_queue: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> (cmd_pop && cmd_head.func == FUNC_WRITE))
      else $error("grid write without a queued write transaction");

endmodule

### tb/grid_bilinear_interpolation_test.sv
module grid_bilinear_interpolation_test;
   import gbi_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam logic signed [31:0] Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] Q_MIN = 32'sh8000_0000;

   typedef struct {
      func_type                      func;
      logic [INDEX_W-1:0]            index;
      logic signed [VALUE_WIDTH-1:0] value;
      logic signed [POS_W-1:0]       pos_x;
      logic signed [POS_W-1:0]       pos_y;
   } grid_req_type;

   typedef struct {
      logic signed [VALUE_WIDTH-1:0] value;
      logic                          clamped;
   } interp_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          req_push = 1'b0;
   logic                          req_full;
   logic                          req_func = 1'b0;
   logic [INDEX_W-1:0]            req_cell_index = '0;
   logic signed [VALUE_WIDTH-1:0] req_cell_value = '0;
   logic signed [POS_W-1:0]       req_pos_x = '0;
   logic signed [POS_W-1:0]       req_pos_y = '0;
   logic                          rsp_empty;
   logic                          rsp_pop = 1'b0;
   logic signed [VALUE_WIDTH-1:0] rsp_interp_value;
   logic                          rsp_clamped;
   logic                          csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]          csr_index = '0;
   logic [CSR_W-1:0]              csr_data = '0;

   // configuration as the block should currently hold it
   logic [CELL_W-1:0]  cfg_cells_x = 6'd62;
   logic [CELL_W-1:0]  cfg_cells_y = 6'd62;
   logic [31:0]        cfg_inv_x = 32'h0001_0000;
   logic [31:0]        cfg_inv_y = 32'h0001_0000;
   logic signed [31:0] cfg_stagger_x = '0;
   logic signed [31:0] cfg_stagger_y = '0;

   logic signed [VALUE_WIDTH-1:0] grid_model [GRID_DEPTH];
   bit                            cell_filled [GRID_DEPTH];

   grid_req_type pending_reqs [$];
   interp_type   expected_interps [$];
   grid_req_type in_flight;

   int items_queued = 0;
   int items_accepted = 0;
   int results_checked = 0;
   int clamped_seen = 0;
   int failures = 0;
   int settings_applied = 0;
   int burst_left = 1;
   int gap_left = 0;
   int hold_left = 0;
   logic [8:0] mon_cycle = '0;

   grid_bilinear_interpolation dut (.*);

   initial begin
      forever #1 clock = ~clock;
   end

   // one axis into grid space: lower cell and Q1.16 weight, clamp is sticky
   function automatic void axis_map(input logic signed [31:0] pos, input logic signed [31:0] off,
                                    input logic [31:0] inv, input logic [CELL_W-1:0] cells,
                                    output logic [CELL_W-1:0] idx, output logic [16:0] frac,
                                    inout bit clamp);
      logic signed [32:0] d;
      logic [63:0] prod, q;
      logic [31:0] whole;
      idx = '0;
      frac = '0;
      d = {pos[31], pos} + {off[31], off};
      if (d < 0) begin
         clamp = 1'b1;
      end else begin
         prod = 64'(d[31:0]) * 64'(inv);
         if (prod < 64'h8000_0000) begin
            clamp = 1'b1;
         end else begin
            q = prod - 64'h8000_0000;
            whole = q[63:32];
            if (whole > 32'(cells)) begin
               idx = cells;
               frac = 17'h1_0000;
               clamp = 1'b1;
            end else begin
               idx = whole[CELL_W-1:0];
               frac = {1'b0, q[31:16]};
            end
         end
      end
   endfunction

   function automatic void locate_cells(input logic signed [31:0] px, py,
                                        output int base, pitch,
                                        output logic [16:0] fx, fy, output bit clamp);
      logic [CELL_W-1:0] ix, iy;
      clamp = 1'b0;
      axis_map(px, cfg_stagger_x, cfg_inv_x, cfg_cells_x, ix, fx, clamp);
      axis_map(py, cfg_stagger_y, cfg_inv_y, cfg_cells_y, iy, fy, clamp);
      pitch = int'(cfg_cells_x) + 2;
      base = int'(ix) + int'(iy) * pitch;
   endfunction

   // past the end of the store reads as zero
   function automatic logic signed [31:0] cell_at(int addr);
      return (addr < GRID_DEPTH) ? grid_model[addr] : '0;
   endfunction

   function automatic interp_type interpolate(input logic signed [31:0] px, py);
      int base, pitch;
      logic [16:0] fx, fy;
      bit clamp;
      logic signed [79:0] v00, v10, v01, v11, wx, wy, one, row0, row1, total, rnd;
      interp_type r;
      locate_cells(px, py, base, pitch, fx, fy, clamp);
      v00 = cell_at(base);
      v10 = cell_at(base + 1);
      v01 = cell_at(base + pitch);
      v11 = cell_at(base + pitch + 1);
      wx = fx;
      wy = fy;
      one = 80'sd65536;
      row0 = v00 * (one - wx) + v10 * wx;
      row1 = v01 * (one - wx) + v11 * wx;
      total = row0 * (one - wy) + row1 * wy;
      rnd = (total + 80'sh8000_0000) >>> 32;
      if (rnd > 80'sh7FFF_FFFF)
         rnd = 80'sh7FFF_FFFF;
      else if (rnd < -80'sh8000_0000)
         rnd = -80'sh8000_0000;
      r.value = rnd[31:0];
      r.clamped = clamp;
      return r;
   endfunction

   function automatic logic signed [31:0] random_value();
      int r;
      r = $urandom_range(0, 7);
      return (r == 0) ? Q_MAX : (r == 1) ? Q_MIN : 32'($urandom);
   endfunction

   function automatic void queue_write(input logic [INDEX_W-1:0] idx,
                                       input logic signed [31:0] val);
      pending_reqs.push_back(grid_req_type'{FUNC_WRITE, idx, val, $urandom, $urandom});
      cell_filled[idx] = 1'b1;
      items_queued++;
   endfunction

   // fills any neighbor not yet written before the query goes out
   function automatic void queue_interp(input logic signed [31:0] px, py);
      int base, pitch;
      logic [16:0] fx, fy;
      bit clamp;
      int addr [4];
      locate_cells(px, py, base, pitch, fx, fy, clamp);
      addr = '{base, base + 1, base + pitch, base + pitch + 1};
      foreach (addr[k])
         if (addr[k] < GRID_DEPTH && !cell_filled[addr[k]])
            queue_write(addr[k][INDEX_W-1:0], random_value());
      pending_reqs.push_back(grid_req_type'{FUNC_INTERP, INDEX_W'($urandom), $urandom, px, py});
      items_queued++;
   endfunction

   // position that lands inside or just around the grid on one axis
   function automatic logic signed [31:0] aim_coord(input logic [CELL_W-1:0] cells,
                                                    input logic [31:0] inv,
                                                    input logic signed [31:0] off);
      longint target, d, p;
      target = longint'($urandom_range(0, (int'(cells) + 3) * 65536)) - 65536;
      if (inv == 0)
         return $urandom;
      d = (target * 65536 + 64'sh8000_0000) / longint'({32'b0, inv});
      p = d - longint'(off);
      if (p > 64'sh7FFF_FFFF || p < -64'sh8000_0000)
         return $urandom;
      return p[31:0];
   endfunction

   // count is in transactions, neighbor fills included
   function automatic void queue_random(int count);
      int sel;
      int stop;
      logic signed [31:0] px, py;
      stop = items_queued + count;
      while (items_queued < stop) begin
         sel = $urandom_range(0, 99);
         if (sel < 18) begin
            queue_write(INDEX_W'($urandom), random_value());
         end else begin
            sel = $urandom_range(0, 9);
            px = (sel < 8) ? aim_coord(cfg_cells_x, cfg_inv_x, cfg_stagger_x) : 32'($urandom);
            py = (sel < 7 || sel == 8) ? aim_coord(cfg_cells_y, cfg_inv_y, cfg_stagger_y)
                                       : 32'($urandom);
            queue_interp(px, py);
         end
      end
   endfunction

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_W-1:0] data);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      case (idx)
         CSR_CELLS_X:    cfg_cells_x = data[CELL_W-1:0];
         CSR_CELLS_Y:    cfg_cells_y = data[CELL_W-1:0];
         CSR_INV_MESH_X: cfg_inv_x = data;
         CSR_INV_MESH_Y: cfg_inv_y = data;
         CSR_STAGGER_X:  cfg_stagger_x = data;
         CSR_STAGGER_Y:  cfg_stagger_y = data;
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [CELL_W-1:0] cx, cy, input logic [31:0] ivx, ivy,
                                 input logic [31:0] sx, sy);
      csr_write(CSR_CELLS_X, (32'($urandom) & ~32'h3F) | 32'(cx));
      csr_write(CSR_CELLS_Y, (32'($urandom) & ~32'h3F) | 32'(cy));
      csr_write(CSR_INV_MESH_X, ivx);
      csr_write(CSR_INV_MESH_Y, ivy);
      csr_write(CSR_STAGGER_X, sx);
      csr_write(CSR_STAGGER_Y, sy);
      csr_write(settings_applied[0] ? CSR_SPARE_HI : CSR_SPARE_LO, $urandom);
      @(posedge clock);
      csr_we <= 1'b0;
      settings_applied++;
   endtask

   task automatic wait_idle();
      do
         @(posedge clock);
      while (items_accepted != items_queued || expected_interps.size() != 0);
      repeat (40) @(posedge clock);
   endtask

   // sender: bursts of transactions separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         req_push <= 1'b0;
         burst_left = 1;
         gap_left = 0;
      end else begin
         if (req_push && !req_full) begin
            items_accepted++;
            if (in_flight.func == FUNC_WRITE)
               grid_model[in_flight.index] = in_flight.value;
            else
               expected_interps.push_back(interpolate(in_flight.pos_x, in_flight.pos_y));
         end
         if (!req_push || !req_full) begin
            if (gap_left > 0) begin
               gap_left--;
               req_push <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               in_flight = pending_reqs.pop_front();
               req_push <= 1'b1;
               req_func <= in_flight.func;
               req_cell_index <= in_flight.index;
               req_cell_value <= in_flight.value;
               req_pos_x <= in_flight.pos_x;
               req_pos_y <= in_flight.pos_y;
               burst_left--;
               if (burst_left == 0) begin
                  burst_left = $urandom_range(1, 40);
                  gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 10);
               end
            end else begin
               req_push <= 1'b0;
            end
         end
      end
   end

   // receiver: checks each result, stalls on a rotating pattern
   always @(posedge clock) begin
      interp_type want;
      if (reset) begin
         rsp_pop <= 1'b0;
         hold_left = 0;
      end else begin
         if (rsp_pop && !rsp_empty) begin
            if (expected_interps.size() == 0) begin
               $display("%0t: unexpected result: expected none, got value %h clamped %b",
                        $time, rsp_interp_value, rsp_clamped);
               failures++;
            end else begin
               want = expected_interps.pop_front();
               if (rsp_interp_value !== want.value) begin
                  $display("%0t: interp_value expected %h got %h",
                           $time, want.value, rsp_interp_value);
                  failures++;
               end
               if (rsp_clamped !== want.clamped) begin
                  $display("%0t: clamped expected %b got %b", $time, want.clamped, rsp_clamped);
                  failures++;
               end
            end
            results_checked++;
            if (rsp_clamped)
               clamped_seen++;
            // long hold-off so the block backs up into its input
            if (results_checked == 100)
               hold_left = 400;
         end
         mon_cycle <= mon_cycle + 1'b1;
         if (hold_left > 0) begin
            hold_left--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= (mon_cycle[8] ? ($urandom_range(0, 3) != 0) : 1'b1)
                       && !(mon_cycle[7] && mon_cycle[1:0] != 2'b00);
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // corners at full scale, below and beyond the grid, exact cell centers
      queue_write(0, Q_MAX);
      queue_write(1, Q_MAX);
      queue_write(64, Q_MAX);
      queue_write(65, Q_MAX);
      queue_write(4095, Q_MIN);
      queue_write(4094, Q_MIN);
      queue_write(4031, Q_MIN);
      queue_write(4030, Q_MIN);
      queue_write(130, 32'sh0);
      queue_interp(32'sh0001_0000, 32'sh0001_0000);
      queue_interp(Q_MAX, Q_MAX);
      queue_interp(32'sh0, 32'sh0);
      queue_interp(Q_MIN, Q_MIN);
      queue_interp(32'sh0000_8000, 32'sh0000_8000);
      queue_interp(32'sh0001_0000, 32'sh0001_8000);
      queue_interp(32'sh003F_0000, 32'sh003F_7FFF);
      queue_interp(32'sh003F_8000, 32'sh0000_8000);
      queue_interp(Q_MIN, Q_MAX);
      queue_interp(32'sh0000_FFFF, 32'sh0001_7FFF);
      queue_random(320);
      wait_idle();

      for (int phase = 1; phase <= 5; phase++) begin
         case (phase)
            1: begin
               // 63 cells: the far neighbors fall past the store
               apply_settings(6'd63, 6'd63, 32'h0001_0000, 32'h0001_0000, '0, '0);
               queue_interp(Q_MAX, Q_MAX);
               queue_interp(32'sh003F_0000, 32'sh003F_0000);
               queue_random(200);
            end
            2: begin
               apply_settings(6'd1, 6'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, Q_MIN, Q_MAX);
               queue_random(150);
            end
            3: begin
               apply_settings(6'd0, 6'd17, 32'h0, 32'h0000_8000,
                              $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                              $urandom_range(0, 32'h0004_0000) - 32'h0002_0000);
               queue_random(150);
            end
            4: begin
               apply_settings(CELL_W'($urandom_range(1, 62)), CELL_W'($urandom_range(1, 62)),
                              $urandom_range(32'h4000, 32'h4_0000),
                              $urandom_range(32'h4000, 32'h4_0000),
                              $urandom_range(0, 32'h0010_0000) - 32'h0008_0000,
                              $urandom_range(0, 32'h0010_0000) - 32'h0008_0000);
               queue_random(300);
            end
            default: begin
               apply_settings(6'd62, 6'd5, $urandom, $urandom_range(32'h8000, 32'h4_0000),
                              $urandom, $urandom);
               queue_random(300);
            end
         endcase
         wait_idle();
      end

      $display("Run covered %0d accepted transactions and %0d checked interpolations",
               items_accepted, results_checked);
      $display("(%0d clamped) over %0d register settings plus the reset one.",
               clamped_seen, settings_applied);
      if (failures == 0)
         $display("grid_bilinear_interpolation: match");
      else
         $display("grid_bilinear_interpolation: mismatch");
      $finish;
   end

   initial begin
      #1_000_000;
      $display("grid_bilinear_interpolation: mismatch");
      $finish;
   end

endmodule

### grid_bilinear_interpolation.f
rtl/core/gbi_pkg.sv
rtl/core/gbi_ram.sv
rtl/core/gbi_front.sv
rtl/core/gbi_cmd_queue.sv
rtl/core/gbi_back.sv
rtl/core/grid_bilinear_interpolation.sv
tb/grid_bilinear_interpolation_test.sv
